### hdl/scl_pkg.sv
`timescale 1ns / 1ps

package scl_pkg;

	// lexer modes; codes 6 and 7 are never entered and decode as idle
	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_WORD = 3'd1,
		MODE_SQ   = 3'd2,
		MODE_DQ   = 3'd3,
		MODE_LT   = 3'd4,
		MODE_GT   = 3'd5
	} lex_mode_t;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} res_kind_t;

	typedef enum logic [2:0] {
		TK_WORD    = 3'd0,
		TK_PIPE    = 3'd1,
		TK_IN      = 3'd2,
		TK_OUT     = 3'd3,
		TK_HEREDOC = 3'd4,
		TK_APPEND  = 3'd5,
		TK_EOL     = 3'd6
	} tok_kind_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_PIPE  = 8'h7C;

	// one input byte raises at most four results
	localparam int MAX_RES = 4;
	localparam int RES_IDX_W = $clog2(MAX_RES);
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		res_kind_t  kind;
		tok_kind_t  tk;
		logic [7:0] ch;
	} res_t;

	// all results of one input byte, in emit order from index 0
	typedef struct packed {
		logic [RES_CNT_W-1:0]    cnt;
		res_t [MAX_RES-1:0]      res;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### hdl/scl_front.sv
`timescale 1ns / 1ps

// Front end: classifies each byte against the lexer mode and packs its results.
module scl_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [7:0]         in_char,
	input  logic               in_last,
	input  scl_pkg::q_stat_t   q_stat,
	output logic               in_ready,
	output logic               push,
	output scl_pkg::bundle_t   push_data
);

	scl_pkg::lex_mode_t mode_q;
	scl_pkg::lex_mode_t mode_nx;
	scl_pkg::bundle_t   bnd;
	logic               redo;
	logic               is_sep;
	logic               is_special;
	logic               accept;

	function automatic scl_pkg::bundle_t add_res(
		input scl_pkg::bundle_t  b,
		input scl_pkg::res_kind_t k,
		input scl_pkg::tok_kind_t t,
		input logic [7:0]        c
	);
		scl_pkg::bundle_t r;
		r = b;
		r.res[b.cnt[scl_pkg::RES_IDX_W-1:0]] = '{kind: k, tk: t, ch: c};
		r.cnt = b.cnt + scl_pkg::RES_CNT_W'(1);
		return r;
	endfunction

	assign is_sep     = (in_char == scl_pkg::CH_SPACE) || (in_char == scl_pkg::CH_TAB);
	assign is_special = (in_char == scl_pkg::CH_PIPE) || (in_char == scl_pkg::CH_LT) ||
	                    (in_char == scl_pkg::CH_GT) || (in_char == scl_pkg::CH_SQ) ||
	                    (in_char == scl_pkg::CH_DQ);

	always_comb begin
		bnd     = '0;
		mode_nx = mode_q;
		redo    = 1'b0;
		if (in_char != scl_pkg::CH_NUL) begin
			case (mode_q)
				scl_pkg::MODE_WORD: begin
					if (is_sep) begin
						bnd = add_res(bnd, scl_pkg::KIND_END, scl_pkg::TK_WORD, 8'd0);
						mode_nx = scl_pkg::MODE_IDLE;
					end else if (is_special) begin
						bnd = add_res(bnd, scl_pkg::KIND_END, scl_pkg::TK_WORD, 8'd0);
						redo = 1'b1;
					end else begin
						bnd = add_res(bnd, scl_pkg::KIND_BYTE, scl_pkg::TK_WORD, in_char);
					end
				end
				scl_pkg::MODE_SQ, scl_pkg::MODE_DQ: begin
					if (in_char == ((mode_q == scl_pkg::MODE_SQ) ? scl_pkg::CH_SQ
					                                              : scl_pkg::CH_DQ)) begin
						bnd = add_res(bnd, scl_pkg::KIND_END, scl_pkg::TK_WORD, 8'd0);
						mode_nx = scl_pkg::MODE_IDLE;
					end else begin
						bnd = add_res(bnd, scl_pkg::KIND_BYTE, scl_pkg::TK_WORD, in_char);
					end
				end
				scl_pkg::MODE_LT: begin
					if (in_char == scl_pkg::CH_LT) begin
						bnd = add_res(bnd, scl_pkg::KIND_END, scl_pkg::TK_HEREDOC, 8'd0);
						mode_nx = scl_pkg::MODE_IDLE;
					end else begin
						bnd = add_res(bnd, scl_pkg::KIND_END, scl_pkg::TK_IN, 8'd0);
						redo = 1'b1;
					end
				end
				scl_pkg::MODE_GT: begin
					if (in_char == scl_pkg::CH_GT) begin
						bnd = add_res(bnd, scl_pkg::KIND_END, scl_pkg::TK_APPEND, 8'd0);
						mode_nx = scl_pkg::MODE_IDLE;
					end else begin
						bnd = add_res(bnd, scl_pkg::KIND_END, scl_pkg::TK_OUT, 8'd0);
						redo = 1'b1;
					end
				end
				default: begin
					redo = 1'b1;
				end
			endcase

			// byte seen from idle: start of a new token
			if (redo) begin
				if (is_sep) begin
					mode_nx = scl_pkg::MODE_IDLE;
				end else if (in_char == scl_pkg::CH_SQ) begin
					mode_nx = scl_pkg::MODE_SQ;
				end else if (in_char == scl_pkg::CH_DQ) begin
					mode_nx = scl_pkg::MODE_DQ;
				end else if (in_char == scl_pkg::CH_PIPE) begin
					bnd = add_res(bnd, scl_pkg::KIND_END, scl_pkg::TK_PIPE, 8'd0);
					mode_nx = scl_pkg::MODE_IDLE;
				end else if (in_char == scl_pkg::CH_LT) begin
					mode_nx = scl_pkg::MODE_LT;
				end else if (in_char == scl_pkg::CH_GT) begin
					mode_nx = scl_pkg::MODE_GT;
				end else begin
					bnd = add_res(bnd, scl_pkg::KIND_BYTE, scl_pkg::TK_WORD, in_char);
					mode_nx = scl_pkg::MODE_WORD;
				end
			end
		end

		// line close: flush open word or held redirect, then EOL; open quote is an error
		if (in_last) begin
			case (mode_nx)
				scl_pkg::MODE_SQ, scl_pkg::MODE_DQ: begin
					bnd = add_res(bnd, scl_pkg::KIND_ERR, scl_pkg::TK_WORD, 8'd0);
				end
				scl_pkg::MODE_WORD: begin
					bnd = add_res(bnd, scl_pkg::KIND_END, scl_pkg::TK_WORD, 8'd0);
				end
				scl_pkg::MODE_LT: begin
					bnd = add_res(bnd, scl_pkg::KIND_END, scl_pkg::TK_IN, 8'd0);
				end
				scl_pkg::MODE_GT: begin
					bnd = add_res(bnd, scl_pkg::KIND_END, scl_pkg::TK_OUT, 8'd0);
				end
				default: begin
				end
			endcase
			if ((mode_nx != scl_pkg::MODE_SQ) && (mode_nx != scl_pkg::MODE_DQ)) begin
				bnd = add_res(bnd, scl_pkg::KIND_END, scl_pkg::TK_EOL, 8'd0);
			end
			mode_nx = scl_pkg::MODE_IDLE;
		end
	end

	assign in_ready  = !q_stat.full;
	assign accept    = in_valid && in_ready;
	assign push      = accept && (bnd.cnt != '0);
	assign push_data = bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= scl_pkg::MODE_IDLE;
		end else if (accept) begin
			mode_q <= mode_nx;
		end
	end

endmodule

### hdl/scl_queue.sv
`timescale 1ns / 1ps

// Short queue of result bundles between front and back.
module scl_queue #(
	parameter int DEPTH = scl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  scl_pkg::bundle_t   push_data,
	input  logic               pop,
	output scl_pkg::bundle_t   head,
	output scl_pkg::q_stat_t   stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	scl_pkg::bundle_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hdl/scl_back.sv
`timescale 1ns / 1ps

// Back end: walks the head bundle one result per cycle into the output register while out_ready allows.
module scl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  scl_pkg::bundle_t   head,
	input  scl_pkg::q_stat_t   q_stat,
	output logic               pop,
	input  logic               out_ready,
	output logic               out_valid,
	output scl_pkg::res_t      out_res,
	output logic               out_last
);

	logic [scl_pkg::RES_IDX_W-1:0] idx_q;
	logic                          valid_q;
	scl_pkg::res_t                 res_q;
	logic                          last_q;
	logic                          load;
	logic                          take;
	logic                          at_end;

	assign load   = !valid_q || out_ready;
	assign take   = load && !q_stat.empty;
	assign at_end = ({1'b0, idx_q} == (head.cnt - scl_pkg::RES_CNT_W'(1)));
	assign pop    = take && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !q_stat.empty;
			if (take) begin
				idx_q <= at_end ? '0 : idx_q + scl_pkg::RES_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q  <= head.res[idx_q];
			last_q <= at_end;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;
	assign out_last  = last_q;

endmodule

### hdl/shell_command_lexer.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake                   Payload
// s_axis   in   s_axis_tvalid/tready        tdata[7:0] char_in; tlast line_end
// m_axis   out  m_axis_tvalid/tready        tdata[7:0] char_out; tuser[1:0] kind,
//                                           tuser[4:2] token_kind; tlast final_res
//
// A byte is taken every cycle while the bundle queue has room; its 0..4 results
// pass through the queue and the output register onto m_axis, one result per
// cycle while m_axis_tready is high, so the output port sets the sustained rate.
// Reset clears the lexer mode, queue pointers and output valid; queue contents
// are don't-care. A stalled m_axis fills the queue and then drops s_axis_tready.

module shell_command_lexer #(
	parameter int QUEUE_DEPTH = scl_pkg::QUEUE_DEPTH_DEF   // bundles in flight, >= 2
) (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,    // [7:0] char_in
	input  logic       s_axis_tlast,    // line_end

	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,    // [7:0] char_out
	output logic [4:0] m_axis_tuser,    // [1:0] kind, [4:2] token_kind
	output logic       m_axis_tlast     // final_res
);

	scl_pkg::q_stat_t q_stat;
	scl_pkg::bundle_t push_data;
	scl_pkg::bundle_t head;
	scl_pkg::res_t    out_res;
	logic             push;
	logic             pop;

	// front: mode tracking, classification, result bundle per request
	scl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_char   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.q_stat    (q_stat),
		.in_ready  (s_axis_tready),
		.push      (push),
		.push_data (push_data)
	);

	// bundles with no results are never queued
	scl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	// back: serializes each bundle, flags its last result
	scl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = out_res.ch;
	assign m_axis_tuser = {out_res.tk, out_res.kind};

	// an error closes the line and nothing follows it from that request
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[1:0] == scl_pkg::KIND_ERR) |-> m_axis_tlast)
		else $error("quote error not last result of its request");

	// end of line is always the last result of its request
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[1:0] == scl_pkg::KIND_END) &&
		(m_axis_tuser[4:2] == scl_pkg::TK_EOL) |-> m_axis_tlast)
		else $error("end-of-line token not last result");

	// the rest of a bundle stays queued, so the next result follows at once
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside a bundle");

	// word bytes carry the word token code
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[1:0] == scl_pkg::KIND_BYTE) |->
		(m_axis_tuser[4:2] == scl_pkg::TK_WORD))
		else $error("word byte with token code");

endmodule

### verif/shell_command_lexer_test.sv
`timescale 1ns / 1ps

// Tracks the lexer state from accepted bytes and checks each emitted result
// against the oldest expected token record.
class lexer_scoreboard;
	typedef struct {
		scl_pkg::res_kind_t  kind;
		scl_pkg::tok_kind_t  tk;
		logic [7:0]          ch;
		logic                fin;
	} lex_token_t;

	lex_token_t          expected_tokens[$];
	lex_token_t          step_tokens[$];
	scl_pkg::lex_mode_t  mode;
	int                  errors;
	int                  checked;

	function new();
		mode = scl_pkg::MODE_IDLE;
		errors = 0;
		checked = 0;
	endfunction

	function void emit_token(scl_pkg::res_kind_t k, scl_pkg::tok_kind_t t, logic [7:0] c);
		lex_token_t e;
		e.kind = k;
		e.tk = t;
		e.ch = c;
		e.fin = 1'b0;
		step_tokens.push_back(e);
	endfunction

	// byte seen with no token open
	function void open_token(logic [7:0] c);
		case (c)
		scl_pkg::CH_SPACE, scl_pkg::CH_TAB: mode = scl_pkg::MODE_IDLE;
		scl_pkg::CH_SQ: mode = scl_pkg::MODE_SQ;
		scl_pkg::CH_DQ: mode = scl_pkg::MODE_DQ;
		scl_pkg::CH_PIPE: begin
			emit_token(scl_pkg::KIND_END, scl_pkg::TK_PIPE, scl_pkg::CH_NUL);
			mode = scl_pkg::MODE_IDLE;
		end
		scl_pkg::CH_LT: mode = scl_pkg::MODE_LT;
		scl_pkg::CH_GT: mode = scl_pkg::MODE_GT;
		default: begin
			emit_token(scl_pkg::KIND_BYTE, scl_pkg::TK_WORD, c);
			mode = scl_pkg::MODE_WORD;
		end
		endcase
	endfunction

	// one accepted request: lex the byte, then close the line if flagged
	function void note_request(logic [7:0] c, logic line_end);
		logic [7:0] closer;
		step_tokens.delete();
		if (c != scl_pkg::CH_NUL) begin
			case (mode)
			scl_pkg::MODE_WORD: begin
				if (c == scl_pkg::CH_SPACE || c == scl_pkg::CH_TAB) begin
					emit_token(scl_pkg::KIND_END, scl_pkg::TK_WORD, scl_pkg::CH_NUL);
					mode = scl_pkg::MODE_IDLE;
				end else if (c == scl_pkg::CH_PIPE || c == scl_pkg::CH_LT ||
						c == scl_pkg::CH_GT || c == scl_pkg::CH_SQ ||
						c == scl_pkg::CH_DQ) begin
					emit_token(scl_pkg::KIND_END, scl_pkg::TK_WORD, scl_pkg::CH_NUL);
					open_token(c);
				end else begin
					emit_token(scl_pkg::KIND_BYTE, scl_pkg::TK_WORD, c);
				end
			end
			scl_pkg::MODE_SQ, scl_pkg::MODE_DQ: begin
				closer = (mode == scl_pkg::MODE_SQ) ? scl_pkg::CH_SQ : scl_pkg::CH_DQ;
				if (c == closer) begin
					emit_token(scl_pkg::KIND_END, scl_pkg::TK_WORD, scl_pkg::CH_NUL);
					mode = scl_pkg::MODE_IDLE;
				end else begin
					emit_token(scl_pkg::KIND_BYTE, scl_pkg::TK_WORD, c);
				end
			end
			scl_pkg::MODE_LT: begin
				if (c == scl_pkg::CH_LT) begin
					emit_token(scl_pkg::KIND_END, scl_pkg::TK_HEREDOC, scl_pkg::CH_NUL);
					mode = scl_pkg::MODE_IDLE;
				end else begin
					emit_token(scl_pkg::KIND_END, scl_pkg::TK_IN, scl_pkg::CH_NUL);
					open_token(c);
				end
			end
			scl_pkg::MODE_GT: begin
				if (c == scl_pkg::CH_GT) begin
					emit_token(scl_pkg::KIND_END, scl_pkg::TK_APPEND, scl_pkg::CH_NUL);
					mode = scl_pkg::MODE_IDLE;
				end else begin
					emit_token(scl_pkg::KIND_END, scl_pkg::TK_OUT, scl_pkg::CH_NUL);
					open_token(c);
				end
			end
			default: open_token(c);
			endcase
		end
		if (line_end) begin
			if (mode == scl_pkg::MODE_SQ || mode == scl_pkg::MODE_DQ) begin
				emit_token(scl_pkg::KIND_ERR, scl_pkg::TK_WORD, scl_pkg::CH_NUL);
			end else begin
				if (mode == scl_pkg::MODE_WORD)
					emit_token(scl_pkg::KIND_END, scl_pkg::TK_WORD, scl_pkg::CH_NUL);
				else if (mode == scl_pkg::MODE_LT)
					emit_token(scl_pkg::KIND_END, scl_pkg::TK_IN, scl_pkg::CH_NUL);
				else if (mode == scl_pkg::MODE_GT)
					emit_token(scl_pkg::KIND_END, scl_pkg::TK_OUT, scl_pkg::CH_NUL);
				emit_token(scl_pkg::KIND_END, scl_pkg::TK_EOL, scl_pkg::CH_NUL);
			end
			mode = scl_pkg::MODE_IDLE;
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].fin = 1'b1;
		foreach (step_tokens[i])
			expected_tokens.push_back(step_tokens[i]);
	endfunction

	task report_mismatch(string msg);
		errors++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	task check_result(logic [7:0] data, logic [4:0] user, logic last);
		lex_token_t e;
		if (expected_tokens.size() == 0) begin
			report_mismatch($sformatf("unexpected result tuser=%h tdata=%h tlast=%b",
				user, data, last));
			return;
		end
		e = expected_tokens.pop_front();
		checked++;
		if (user[1:0] !== e.kind)
			report_mismatch($sformatf("kind %0d, expected %0d", user[1:0], e.kind));
		if (user[4:2] !== e.tk)
			report_mismatch($sformatf("token_kind %0d, expected %0d", user[4:2], e.tk));
		if (data !== e.ch)
			report_mismatch($sformatf("char_out %h, expected %h", data, e.ch));
		if (last !== e.fin)
			report_mismatch($sformatf("final_res %b, expected %b", last, e.fin));
	endtask
endclass

module shell_command_lexer_test;

	localparam int IDLE_LIMIT = 1000;   // cycles with no handshake at all
	localparam int TOTAL_ITEMS = 345;   // requests in the whole run, directed ones included
	localparam int CALM_TAIL = 60;      // last requests go without idling

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic [4:0] m_axis_tuser;
	logic       m_axis_tlast;

	lexer_scoreboard sb;
	logic            gaps_on;
	int              sent_items;
	int              sent_lines;
	logic [7:0]      line_buf[$];

	shell_command_lexer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// handshakes are sampled at the rising edge, before any register update
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			sb.note_request(s_axis_tdata, s_axis_tlast);
			sent_items++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// result sink: random stall bursts while gaps are enabled
	initial begin
		m_axis_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog: ends the run if neither side moves for too long
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) ||
					(m_axis_tvalid && m_axis_tready))
				idle = 0;
			else
				idle++;
		end
		$display("watchdog: no handshake for %0d cycles, %0d results still due",
			IDLE_LIMIT, sb.expected_tokens.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] c, input logic last);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		if (last)
			sent_lines++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s, input logic close);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], close && (i == s.len() - 1));
	endtask

	// plain word byte: half letters, half any non-NUL byte that is no separator or operator
	function automatic logic [7:0] word_char();
		logic [7:0] c;
		if ($urandom_range(0, 1)) begin
			c = 8'h61 + 8'($urandom_range(0, 25));
		end else begin
			do c = 8'($urandom_range(1, 255));
			while (c == scl_pkg::CH_SPACE || c == scl_pkg::CH_TAB ||
				c == scl_pkg::CH_PIPE || c == scl_pkg::CH_LT ||
				c == scl_pkg::CH_GT || c == scl_pkg::CH_SQ || c == scl_pkg::CH_DQ);
		end
		return c;
	endfunction

	// mostly well-formed command lines with random content, some noise
	task automatic build_line();
		int         ntok;
		int         n;
		logic [7:0] q;
		logic [7:0] r;
		line_buf.delete();
		ntok = $urandom_range(1, 6);
		for (int t = 0; t < ntok; t++) begin
			case ($urandom_range(0, 11))
			0, 1, 2, 3: begin
				n = $urandom_range(1, 5);
				repeat (n) line_buf.push_back(word_char());
			end
			4: repeat ($urandom_range(1, 3))
				line_buf.push_back($urandom_range(0, 1) ? scl_pkg::CH_SPACE
				                                        : scl_pkg::CH_TAB);
			5: line_buf.push_back(scl_pkg::CH_PIPE);
			6: line_buf.push_back(scl_pkg::CH_LT);
			7: line_buf.push_back(scl_pkg::CH_GT);
			8: begin
				q = $urandom_range(0, 1) ? scl_pkg::CH_LT : scl_pkg::CH_GT;
				line_buf.push_back(q);
				line_buf.push_back(q);
			end
			9: begin
				q = $urandom_range(0, 1) ? scl_pkg::CH_SQ : scl_pkg::CH_DQ;
				line_buf.push_back(q);
				repeat ($urandom_range(0, 4)) begin
					r = 8'($urandom_range(0, 255));
					line_buf.push_back((r == q) ? 8'h2E : r);
				end
				line_buf.push_back(q);
			end
			10: line_buf.push_back(scl_pkg::CH_NUL);
			default: line_buf.push_back(8'($urandom_range(0, 255)));
			endcase
			if ($urandom_range(0, 9) < 6)
				line_buf.push_back(scl_pkg::CH_SPACE);
		end
		// now and then a quote left open at line end
		if ($urandom_range(0, 9) == 0) begin
			q = $urandom_range(0, 1) ? scl_pkg::CH_SQ : scl_pkg::CH_DQ;
			line_buf.push_back(q);
			repeat ($urandom_range(0, 3)) line_buf.push_back(word_char());
		end
		// line end sometimes rides on a byte with no character
		if ($urandom_range(0, 5) == 0)
			line_buf.push_back(scl_pkg::CH_NUL);
	endtask

	initial begin
		int n;
		sb = new();
		gaps_on = 1'b0;
		sent_items = 0;
		sent_lines = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = scl_pkg::CH_NUL;
		s_axis_tlast = 1'b0;
		clk = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: operators, quoting rules, held redirections, line closing
		send_text("a|b", 1'b0);             // pipe cuts a word
		send_byte(8'hFF, 1'b0);             // top byte inside a word
		send_byte(scl_pkg::CH_TAB, 1'b0);   // tab ends the word
		send_text("<<x>", 1'b0);            // heredoc, word, held '>'
		send_byte(scl_pkg::CH_NUL, 1'b0);   // empty byte keeps '>' held
		send_text(">'", 1'b0);              // append, then open single quote
		send_text("'", 1'b0);               // empty quoted pair
		send_text("q\"", 1'b0);             // quote right after a word
		send_text("| \"", 1'b0);            // operators are literal in quotes
		send_byte(8'h01, 1'b1);             // word closed by line end
		send_byte(scl_pkg::CH_LT, 1'b1);    // held '<' flushed at line end
		send_byte(scl_pkg::CH_GT, 1'b1);    // held '>' flushed at line end
		send_text("'a", 1'b1);              // unclosed quote error
		send_byte(scl_pkg::CH_GT, 1'b0);
		send_byte(8'h80, 1'b1);             // four results from one request
		send_byte(scl_pkg::CH_NUL, 1'b1);   // bare end of line

		// random lines; idling stops for the tail of the run
		gaps_on = 1'b1;
		while (sent_items < TOTAL_ITEMS) begin
			build_line();
			n = line_buf.size();
			for (int i = 0; i < n; i++) begin
				if (sent_items >= TOTAL_ITEMS - CALM_TAIL)
					gaps_on = 1'b0;
				send_byte(line_buf[i], i == n - 1);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (sb.expected_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d requests over %0d command lines", sent_items, sent_lines);
		$display("checked %0d results, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### shell_command_lexer.f
hdl/scl_pkg.sv
hdl/scl_front.sv
hdl/scl_queue.sv
hdl/scl_back.sv
hdl/shell_command_lexer.sv
verif/shell_command_lexer_test.sv
